/* hdl/rncp_pkg.sv */
// Shared constants, types and register indexes of the ranked nearest click picker.
package rncp_pkg;
  localparam int MAX_POINTS = 512;
  localparam int COORD_BITS = 12;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DIST_W     = SQ_W + 1;
  localparam int KEY_W      = DIST_W + IDX_W;
  localparam int RAD_W      = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOCATION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_RADIUS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_DIST_SQ   = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CLICK = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [KEY_W-1:0]      key_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    coord_t wx;
    coord_t wy;
    idx_t   raddr;
  } pt_ctl_t;
endpackage

/* hdl/rncp_point_mem.sv */
// Point position table: one write port for loads, one registered read port for the scan.
module rncp_point_mem (
  input  logic             clk,
  input  rncp_pkg::pt_ctl_t ctl,
  output rncp_pkg::coord_t rd_x,
  output rncp_pkg::coord_t rd_y
);
  import rncp_pkg::*;

  coord_t mem_x [MAX_POINTS];
  coord_t mem_y [MAX_POINTS];
  coord_t rd_x_r;
  coord_t rd_y_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_x[ctl.waddr] <= ctl.wx;
      mem_y[ctl.waddr] <= ctl.wy;
    end
    rd_x_r <= mem_x[ctl.raddr];
    rd_y_r <= mem_y[ctl.raddr];
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;
endmodule

/* hdl/rncp_dist_mem.sv */
// Snapshot of squared distances taken at the last new click, indexed by point.
module rncp_dist_mem (
  input  logic            clk,
  input  logic            we,
  input  rncp_pkg::idx_t  waddr,
  input  rncp_pkg::dist_t wdata,
  input  rncp_pkg::idx_t  raddr,
  output rncp_pkg::dist_t rdata
);
  import rncp_pkg::*;

  dist_t mem [MAX_POINTS];
  dist_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* hdl/rncp_sq_unit.sv */
// Shared squarer: square of the absolute difference of two coordinates.
module rncp_sq_unit (
  input  rncp_pkg::coord_t a,
  input  rncp_pkg::coord_t b,
  output logic [rncp_pkg::SQ_W-1:0] sq
);
  import rncp_pkg::*;

  coord_t diff;

  assign diff = (a >= b) ? (a - b) : (b - a);
  assign sq   = SQ_W'(diff) * SQ_W'(diff);
endmodule

/* hdl/ranked_nearest_click_picker_top.sv */
// A new click scans the N active points, for each a point table read, then the shared
// squarer for x and for y; a repeated click walks the stored distance snapshot, a read
// and a compare per point, to find the next candidate in rank order. A load is written
// straight from the idle state. The block takes no item while a click is in work, and a
// result that waits on out_ready adds its wait; the result register frees the input side
// once a result is out.
module ranked_nearest_click_picker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [rncp_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [rncp_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic [rncp_pkg::COORD_BITS-1:0] in_pos_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rncp_pkg::IDX_W-1:0]  out_selected_index,
  output logic [rncp_pkg::DIST_W-1:0] out_selected_dist,
  output logic [rncp_pkg::CNT_W-1:0]  out_ring_size,
  output logic                        out_was_repeat,
  input  logic                        cfg_we,
  input  logic [rncp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rncp_pkg::DIST_W-1:0] cfg_wdata
);
  import rncp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_SQX  = 7'b0000100,
    S_SQY  = 7'b0001000,
    S_DRD  = 7'b0010000,
    S_DCMP = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  cnt_t               loc_cnt_r;
  logic [RAD_W-1:0]   snap_r;
  dist_t              keep_r;

  cnt_t   kept_r, kept_nxt;
  idx_t   pos_r, pos_nxt;
  coord_t last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  cnt_t   n_r, n_nxt;
  idx_t   idx_r, idx_nxt;
  logic   new_r, new_nxt;
  logic   found_r, found_nxt;
  key_t   best_r, best_nxt;
  key_t   prev_r, prev_nxt;
  cnt_t   le_cnt_r, le_cnt_nxt;
  logic [SQ_W-1:0] sqx_r, sqx_nxt;

  logic   out_valid_r, out_valid_nxt;
  idx_t   out_idx_r, out_idx_nxt;
  dist_t  out_dist_r, out_dist_nxt;
  cnt_t   out_ring_r, out_ring_nxt;
  logic   out_rep_r, out_rep_nxt;

  pt_ctl_t pt_ctl;
  coord_t  rd_x, rd_y;
  logic    dm_we;
  dist_t   dm_rdata;
  coord_t  sq_a, sq_b;
  logic [SQ_W-1:0] sq;

  logic signed [COORD_BITS+1:0] dx, dy, rad;
  logic   is_repeat;
  cnt_t   n_eff;
  dist_t  cur_d;
  key_t   cur_key;
  logic   cand_ok;
  logic   take;
  logic   last_pt;
  idx_t   pos_inc;
  logic   best_le;

  rncp_point_mem u_pmem (
    .clk  (clk),
    .ctl  (pt_ctl),
    .rd_x (rd_x),
    .rd_y (rd_y)
  );

  rncp_dist_mem u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (idx_r),
    .wdata (cur_d),
    .raddr (idx_r),
    .rdata (dm_rdata)
  );

  rncp_sq_unit u_sq (
    .a  (sq_a),
    .b  (sq_b),
    .sq (sq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_cnt_r <= CNT_W'(1);
      snap_r    <= RAD_W'(5);
      keep_r    <= DIST_W'(2500);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCATION_COUNT: loc_cnt_r <= cfg_wdata[CNT_W-1:0];
        REG_SNAP_RADIUS:    snap_r    <= cfg_wdata[RAD_W-1:0];
        REG_KEEP_DIST_SQ:   keep_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  assign dx  = $signed({2'b00, in_pos_x}) - $signed({2'b00, last_x_r});
  assign dy  = $signed({2'b00, in_pos_y}) - $signed({2'b00, last_y_r});
  assign rad = $signed({{(COORD_BITS+2-RAD_W){1'b0}}, snap_r});
  assign is_repeat = (kept_r != '0) && (dx < rad) && (dx > -rad) && (dy < rad) && (dy > -rad);

  always_comb begin
    if (loc_cnt_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (loc_cnt_r > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = loc_cnt_r;
    end
  end

  assign sq_a = (state_r == S_SQX) ? rd_x : rd_y;
  assign sq_b = (state_r == S_SQX) ? last_x_r : last_y_r;

  assign cur_d   = (state_r == S_SQY) ? (DIST_W'(sqx_r) + DIST_W'(sq)) : dm_rdata;
  // higher index ranks first among equal distances
  assign cur_key = {cur_d, ~idx_r};
  assign cand_ok = new_r || (pos_r == '0) || (cur_key > prev_r);
  assign take    = cand_ok && (!found_r || (cur_key < best_r));
  assign last_pt = ({1'b0, idx_r} == (n_r - CNT_W'(1)));
  assign pos_inc = pos_r + IDX_W'(1);
  assign best_le = (best_r[KEY_W-1:IDX_W] <= keep_r);
  assign dm_we   = (state_r == S_SQY);

  always_comb begin
    pt_ctl.we    = 1'b0;
    pt_ctl.waddr = in_entry_index;
    pt_ctl.wx    = in_pos_x;
    pt_ctl.wy    = in_pos_y;
    pt_ctl.raddr = idx_r;

    state_nxt  = state_r;
    kept_nxt   = kept_r;
    pos_nxt    = pos_r;
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    n_nxt      = n_r;
    idx_nxt    = idx_r;
    new_nxt    = new_r;
    found_nxt  = found_r;
    best_nxt   = best_r;
    prev_nxt   = prev_r;
    le_cnt_nxt = le_cnt_r;
    sqx_nxt    = sqx_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_dist_nxt  = out_dist_r;
    out_ring_nxt  = out_ring_r;
    out_rep_nxt   = out_rep_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (in_opcode == OP_LOAD) begin
            pt_ctl.we = 1'b1;
          end else if (is_repeat) begin
            new_nxt = 1'b0;
            pos_nxt = ({1'b0, pos_inc} >= kept_r) ? '0 : pos_inc;
            state_nxt = S_DRD;
          end else begin
            new_nxt    = 1'b1;
            pos_nxt    = '0;
            n_nxt      = n_eff;
            le_cnt_nxt = '0;
            last_x_nxt = in_pos_x;
            last_y_nxt = in_pos_y;
            state_nxt  = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_SQX;
      end
      S_SQX: begin
        sqx_nxt   = sq;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        if (cur_d <= keep_r) begin
          le_cnt_nxt = le_cnt_r + CNT_W'(1);
        end
        if (take) begin
          best_nxt  = cur_key;
          found_nxt = 1'b1;
        end
        if (last_pt) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_DRD: begin
        state_nxt = S_DCMP;
      end
      S_DCMP: begin
        if (take) begin
          best_nxt  = cur_key;
          found_nxt = 1'b1;
        end
        if (last_pt) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_DRD;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = ~best_r[IDX_W-1:0];
          out_dist_nxt  = best_r[KEY_W-1:IDX_W];
          out_rep_nxt   = !new_r;
          prev_nxt      = best_r;
          if (new_r) begin
            kept_nxt     = le_cnt_r + CNT_W'(1) - CNT_W'(best_le);
            out_ring_nxt = le_cnt_r + CNT_W'(1) - CNT_W'(best_le);
          end else begin
            out_ring_nxt = kept_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kept_r      <= '0;
      pos_r       <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      n_r         <= CNT_W'(1);
      idx_r       <= '0;
      new_r       <= 1'b0;
      found_r     <= 1'b0;
      le_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_r      <= kept_nxt;
      pos_r       <= pos_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      new_r       <= new_nxt;
      found_r     <= found_nxt;
      le_cnt_r    <= le_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    prev_r     <= prev_nxt;
    sqx_r      <= sqx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_dist_r <= out_dist_nxt;
    out_ring_r <= out_ring_nxt;
    out_rep_r  <= out_rep_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_selected_index = out_idx_r;
  assign out_selected_dist  = out_dist_r;
  assign out_ring_size      = out_ring_r;
  assign out_was_repeat     = out_rep_r;
endmodule

/* test/tb_top.sv */
// Self-checking testbench for the ranked nearest click picker.
module tb_top;
  import rncp_pkg::*;

  typedef struct {
    idx_t                    index;
    logic [DIST_W-1:0]       pick_dist;
    cnt_t                    ring;
    logic                    repeat_flag;
  } pick_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_opcode = OP_LOAD;
  idx_t                   in_entry_index = '0;
  coord_t                 in_pos_x = '0;
  coord_t                 in_pos_y = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  idx_t                   out_selected_index;
  logic [DIST_W-1:0]      out_selected_dist;
  cnt_t                   out_ring_size;
  logic                   out_was_repeat;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DIST_W-1:0]      cfg_wdata = '0;

  ranked_nearest_click_picker_top i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow state of the picker
  int unsigned  loc_count = 1;
  int unsigned  snap_rad = 5;
  longint       keep_limit = 2500;
  int unsigned  tab_x [MAX_POINTS];
  int unsigned  tab_y [MAX_POINTS];
  int unsigned  rank_idx [MAX_POINTS];
  longint       rank_dist [MAX_POINTS];
  int unsigned  kept = 0;
  int unsigned  cyc_pos = 0;
  int           last_x = -1;
  int           last_y = -1;

  pick_t        pending_picks [$];
  int           err_count = 0;
  int           load_count = 0;
  int           click_count = 0;
  int           repeat_count = 0;
  longint       cycle_count = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void rank_click(int cx, int cy);
    int unsigned n, k;
    longint d, dx, dy;
    n = loc_count;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    for (int unsigned i = 0; i < n; i++) begin
      dx = longint'(tab_x[i]) - cx;
      dy = longint'(tab_y[i]) - cy;
      d = dx * dx + dy * dy;
      k = i;
      // equal distance: the newer, higher index moves ahead
      while (k > 0 && rank_dist[k-1] >= d) begin
        rank_dist[k] = rank_dist[k-1];
        rank_idx[k] = rank_idx[k-1];
        k--;
      end
      rank_dist[k] = d;
      rank_idx[k] = i;
    end
    kept = 1;
    while (kept < n && rank_dist[kept] <= keep_limit) kept++;
    cyc_pos = 0;
    last_x = cx;
    last_y = cy;
  endfunction

  function automatic void predict_item(logic op, idx_t idx, coord_t x, coord_t y);
    pick_t p;
    int    dx, dy, r;
    bit    rep;
    if (op == OP_LOAD) begin
      tab_x[idx] = x;
      tab_y[idx] = y;
      load_count++;
      return;
    end
    rep = 1'b0;
    if (kept != 0) begin
      dx = int'(x) - last_x;
      dy = int'(y) - last_y;
      r = snap_rad;
      rep = dx < r && dx > -r && dy < r && dy > -r;
    end
    if (rep) begin
      cyc_pos++;
      if (cyc_pos >= kept) cyc_pos = 0;
      repeat_count++;
    end else begin
      rank_click(x, y);
    end
    p.index = idx_t'(rank_idx[cyc_pos]);
    p.pick_dist = DIST_W'(rank_dist[cyc_pos]);
    p.ring = CNT_W'(kept);
    p.repeat_flag = rep;
    pending_picks.push_back(p);
    click_count++;
  endfunction

  task automatic send_item(logic op, idx_t idx, coord_t x, coord_t y);
    int g;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_entry_index <= idx;
    in_pos_x <= x;
    in_pos_y <= y;
    do @(posedge clk); while (!in_ready);
    predict_item(op, idx, x, y);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // drop valid and hold until every pick has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= DIST_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOCATION_COUNT: loc_count = data & 32'h3FF;
      REG_SNAP_RADIUS:    snap_rad = data & 32'h1F;
      REG_KEEP_DIST_SQ:   keep_limit = data & 32'h1FFFFFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned cnt, int unsigned rad, int unsigned lim);
    wait_idle();
    write_reg(REG_LOCATION_COUNT, cnt);
    write_reg(REG_SNAP_RADIUS, rad);
    write_reg(REG_KEEP_DIST_SQ, lim);
  endtask

  function automatic coord_t near_coord(int c, int r);
    int v;
    v = c + $urandom_range(0, 2 * r) - r;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return coord_t'(v);
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, 4095));
  endfunction

  // write every slot first so that no click ever ranks an unwritten entry
  task automatic test_fill_table();
    for (int i = 0; i < MAX_POINTS; i++)
      send_item(OP_LOAD, idx_t'(i), rand_coord(), rand_coord());
  endtask

  task automatic test_directed();
    set_regs(8, 5, 2500);
    send_item(OP_LOAD, 0, 0, 0);
    send_item(OP_LOAD, 1, 4095, 4095);
    send_item(OP_LOAD, 2, 100, 100);
    send_item(OP_LOAD, 3, 100, 100);
    send_item(OP_LOAD, 4, 110, 100);
    send_item(OP_CLICK, 0, 100, 100);
    send_item(OP_CLICK, 0, 102, 98);
    send_item(OP_CLICK, 0, 101, 100);
    send_item(OP_CLICK, 0, 100, 101);
    send_item(OP_CLICK, 0, 4095, 4095);
    send_item(OP_CLICK, 0, 0, 4095);
    set_regs(0, 0, 0);
    send_item(OP_CLICK, 0, 0, 0);
    send_item(OP_CLICK, 0, 0, 0);
    set_regs(1023, 31, 33538050);
    send_item(OP_CLICK, 0, 4095, 0);
    send_item(OP_CLICK, 0, 4070, 30);
    send_item(OP_CLICK, 0, 4080, 20);
    set_regs(512, 1, 33554431);
    send_item(OP_CLICK, 0, 2048, 2048);
    send_item(OP_CLICK, 0, 2048, 2048);
  endtask

  task automatic test_random_phases();
    int unsigned cnt, rad, lim;
    int r;
    for (int ph = 0; ph < 12; ph++) begin
      cnt = (ph % 5 == 4) ? 512 : $urandom_range(0, 40);
      rad = $urandom_range(0, 31);
      case ($urandom_range(0, 3))
        0: lim = 0;
        1: lim = $urandom_range(0, 300000);
        2: lim = 33538050;
        default: lim = $urandom_range(0, 33554431);
      endcase
      set_regs(cnt, rad, lim);
      for (int n = 0; n < ((cnt == 512) ? 15 : 45); n++) begin
        r = $urandom_range(0, 99);
        if (r < 30)
          send_item(OP_LOAD, idx_t'($urandom_range(0, 511)), rand_coord(), rand_coord());
        else if (r < 75 && last_x >= 0)
          send_item(OP_CLICK, idx_t'($urandom), near_coord(last_x, snap_rad),
                    near_coord(last_y, snap_rad));
        else
          send_item(OP_CLICK, idx_t'($urandom), rand_coord(), rand_coord());
      end
      if (ph == 6) wait_idle();
    end
  endtask

  // compare each pick against the oldest prediction; stall out_ready at random
  int out_hold = 0;
  always @(posedge clk) begin
    pick_t p;
    if (rst_n && out_valid && out_ready) begin
      if (pending_picks.size() == 0) begin
        $error("unexpected pick: index %0d", out_selected_index);
        err_count++;
      end else begin
        p = pending_picks.pop_front();
        if (out_selected_index !== p.index) begin
          $error("selected_index exp %0d got %0d", p.index, out_selected_index);
          err_count++;
        end
        if (out_selected_dist !== p.pick_dist) begin
          $error("selected_dist exp %0d got %0d", p.pick_dist, out_selected_dist);
          err_count++;
        end
        if (out_ring_size !== p.ring) begin
          $error("ring_size exp %0d got %0d", p.ring, out_ring_size);
          err_count++;
        end
        if (out_was_repeat !== p.repeat_flag) begin
          $error("was_repeat exp %0d got %0d", p.repeat_flag, out_was_repeat);
          err_count++;
        end
      end
    end
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_hold <= gap_len();
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("ranked_nearest_click_picker_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_table();
    test_directed();
    test_random_phases();
    wait_idle();
    $display("covered %0d loads and %0d clicks, %0d of them repeats",
             load_count, click_count, repeat_count);
    if (err_count == 0)
      $display("ranked_nearest_click_picker_top: match");
    else
      $display("ranked_nearest_click_picker_top: mismatch");
    $finish;
  end
endmodule
